/* sv/in_order_response_reorder_top_macros.svh */
// Assertion macros for the in-order response reorder block.
`ifndef IN_ORDER_RESPONSE_REORDER_TOP_MACROS_SVH
`define IN_ORDER_RESPONSE_REORDER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IOR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define IOR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ior_pkg.sv */
// Shared types and constants for the in-order response reorder block.
`timescale 1ns / 1ps

package ior_pkg;

  localparam int SEQ_BITS     = 16;
  localparam int HANDLE_BITS  = 32;
  localparam int WINDOW_SLOTS = 16;

  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  typedef struct packed {
    logic [SEQ_BITS-1:0]    sequence_number;
    logic [HANDLE_BITS-1:0] payload_handle;
  } in_item_t;

  typedef struct packed {
    logic                   result_kind;
    logic [SEQ_BITS-1:0]    released_sequence;
    logic [HANDLE_BITS-1:0] released_handle;
    logic                   last_of_run;
  } out_item_t;

  // Strobes from the sequencer to the slot store.
  typedef struct packed {
    logic wr_en;   // store handle, mark slot valid
    logic clr_en;  // drop the valid mark of the drained slot
    logic rd_en;   // fetch a held handle
  } slot_cmd_t;

endpackage

/* sv/ior_slot_store.sv */
// Window slot store: valid marks in flops, held handles in a memory.
`timescale 1ns / 1ps

module ior_slot_store
  import ior_pkg::*;
#(
  parameter int WINDOW_SLOTS = ior_pkg::WINDOW_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  slot_cmd_t                       cmd,
  input  logic [$clog2(WINDOW_SLOTS)-1:0] wr_addr,
  input  logic [$clog2(WINDOW_SLOTS)-1:0] clr_addr,
  input  logic [$clog2(WINDOW_SLOTS)-1:0] rd_addr,
  input  logic [HANDLE_BITS-1:0]          wr_data,
  output logic [HANDLE_BITS-1:0]          rd_data,
  output logic [WINDOW_SLOTS-1:0]         slot_valid
);

  logic [HANDLE_BITS-1:0]  handle_mem [WINDOW_SLOTS];
  logic [HANDLE_BITS-1:0]  rd_data_r;
  logic [WINDOW_SLOTS-1:0] valid_r;
  logic [WINDOW_SLOTS-1:0] valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
    if (cmd.clr_en) begin
      valid_nxt[clr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      handle_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= handle_mem[rd_addr];
    end
  end

  assign rd_data    = rd_data_r;
  assign slot_valid = valid_r;

endmodule

/* sv/in_order_response_reorder_top.sv */
// Top level of the in-order response reorder buffer.
//
// Responses come in on in_data with a wrapping sequence number; early ones within
// WINDOW_SLOTS of the expected number are held, and the expected one is released
// on out_data together with every held successor, in order, last_of_run on the
// final one. Out-of-window or duplicate responses come back once with
// result_kind set. One item is worked at a time: an early arrival or a reject is
// accepted and then evaluated, and an expected arrival with held successors is
// also drained, the drain loop reading one held handle per cycle while out_free
// lets results out, through the single read port of the handle memory. Cycles in
// which out_ready holds a result back lengthen each of these. Valid marks reset at once.
`timescale 1ns / 1ps

module in_order_response_reorder_top
  import ior_pkg::*;
#(
  parameter int WINDOW_SLOTS = ior_pkg::WINDOW_SLOTS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

`include "in_order_response_reorder_top_macros.svh"

  localparam int IDXW = $clog2(WINDOW_SLOTS);
  localparam logic [IDXW:0]         SLOTS_W = (IDXW+1)'(WINDOW_SLOTS);
  localparam logic [SEQ_BITS-1:0]   SLOTS_S = SEQ_BITS'(WINDOW_SLOTS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [SEQ_BITS-1:0] exp_r, exp_nxt;
  logic [IDXW-1:0]     head_r, head_nxt;
  in_item_t            in_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, res;
  logic                load;
  logic                out_free;

  logic [SEQ_BITS-1:0] delta;
  logic                in_window;
  logic [IDXW:0]       slot_sum, head_sum;
  logic [IDXW-1:0]     slot_idx, head_inc;

  slot_cmd_t               cmd;
  logic [HANDLE_BITS-1:0]  rd_data;
  logic [WINDOW_SLOTS-1:0] slot_valid;

  ior_slot_store #(
    .WINDOW_SLOTS(WINDOW_SLOTS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_addr   (slot_idx),
    .clr_addr  (head_r),
    .rd_addr   (head_inc),
    .wr_data   (in_r.payload_handle),
    .rd_data   (rd_data),
    .slot_valid(slot_valid)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Offset from the expected number (mod 2^SEQ_BITS) and slot position (mod window size).
  assign delta     = in_r.sequence_number - exp_r;
  assign in_window = (delta < SLOTS_S);
  assign slot_sum  = {1'b0, head_r} + {1'b0, delta[IDXW-1:0]};
  assign slot_idx  = (slot_sum >= SLOTS_W) ? IDXW'(slot_sum - SLOTS_W) : slot_sum[IDXW-1:0];
  assign head_sum  = {1'b0, head_r} + {{IDXW{1'b0}}, 1'b1};
  assign head_inc  = (head_sum >= SLOTS_W) ? IDXW'(head_sum - SLOTS_W) : head_sum[IDXW-1:0];

  always_comb begin
    state_nxt = state_r;
    exp_nxt   = exp_r;
    head_nxt  = head_r;
    load      = 1'b0;
    cmd       = '0;
    res       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          if (!in_window || (delta != '0 && slot_valid[slot_idx])) begin
            load = 1'b1;
            res  = '{result_kind: KIND_REJECT,
                     released_sequence: in_r.sequence_number,
                     released_handle: in_r.payload_handle,
                     last_of_run: 1'b1};
          end else if (delta != '0) begin
            cmd.wr_en = 1'b1;
          end else begin
            load     = 1'b1;
            res      = '{result_kind: KIND_RELEASE,
                         released_sequence: in_r.sequence_number,
                         released_handle: in_r.payload_handle,
                         last_of_run: !slot_valid[head_inc]};
            exp_nxt  = exp_r + 1'b1;
            head_nxt = head_inc;
            if (slot_valid[head_inc]) begin
              cmd.rd_en = 1'b1;
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          load       = 1'b1;
          res        = '{result_kind: KIND_RELEASE,
                         released_sequence: exp_r,
                         released_handle: rd_data,
                         last_of_run: !slot_valid[head_inc]};
          cmd.clr_en = 1'b1;
          exp_nxt    = exp_r + 1'b1;
          head_nxt   = head_inc;
          if (slot_valid[head_inc]) begin
            cmd.rd_en = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      exp_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IOR_ASSERT_NOW(a_drain_head_held, (state_r == ST_DRAIN), slot_valid[head_r],
    "drain entered on an empty slot")
  `IOR_ASSERT_NOW(a_idle_head_empty, (state_r == ST_IDLE), !slot_valid[head_r],
    "held response left at the head slot")
  `IOR_ASSERT_NEXT(a_drain_seq, (state_r == ST_DRAIN && out_free),
    (out_valid_r && out_data_r.result_kind == KIND_RELEASE &&
     out_data_r.released_sequence == $past(exp_r)),
    "drained result out of sequence")

endmodule

/* bench/in_order_response_reorder_checker.sv */
// Checker for the in-order response reorder block: predicts releases and compares results.
`timescale 1ns / 1ps

module in_order_response_reorder_checker
  import ior_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  logic [SEQ_BITS-1:0]    next_seq;
  logic                   held_valid [WINDOW_SLOTS];
  logic [HANDLE_BITS-1:0] held_handle [WINDOW_SLOTS];
  int unsigned            head_slot;
  out_item_t              release_queue [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic out_item_t make_result(input logic kind, input logic [SEQ_BITS-1:0] seq,
                                            input logic [HANDLE_BITS-1:0] handle);
    out_item_t r;
    r.result_kind       = kind;
    r.released_sequence = seq;
    r.released_handle   = handle;
    r.last_of_run       = 1'b0;
    return r;
  endfunction

  task automatic advance_window();
    next_seq  = next_seq + 1'b1;
    head_slot = (head_slot + 1) % WINDOW_SLOTS;
  endtask

  // Works out the results one accepted response causes and queues them.
  task automatic predict_response(input in_item_t item);
    logic [SEQ_BITS-1:0] offset;
    int unsigned         slot;
    int                  n;
    out_item_t           cur;
    offset = item.sequence_number - next_seq;
    if (offset >= WINDOW_SLOTS) begin
      cur = make_result(KIND_REJECT, item.sequence_number, item.payload_handle);
      cur.last_of_run = 1'b1;
      release_queue.push_back(cur);
    end else if (offset != 0) begin
      slot = (head_slot + offset) % WINDOW_SLOTS;
      if (held_valid[slot]) begin
        // duplicate: held entry stays as it is
        cur = make_result(KIND_REJECT, item.sequence_number, item.payload_handle);
        cur.last_of_run = 1'b1;
        release_queue.push_back(cur);
      end else begin
        held_valid[slot]  = 1'b1;
        held_handle[slot] = item.payload_handle;
      end
    end else begin
      cur = make_result(KIND_RELEASE, item.sequence_number, item.payload_handle);
      advance_window();
      n = 1;
      while (held_valid[head_slot] && n < WINDOW_SLOTS) begin
        release_queue.push_back(cur);
        cur = make_result(KIND_RELEASE, next_seq, held_handle[head_slot]);
        held_valid[head_slot] = 1'b0;
        advance_window();
        n++;
      end
      cur.last_of_run = 1'b1;
      release_queue.push_back(cur);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (release_queue.size() == 0) begin
      report_mismatch($sformatf("unexpected result seq %h handle %h",
                                got.released_sequence, got.released_handle));
    end else begin
      want = release_queue.pop_front();
      if (got.result_kind !== want.result_kind)
        report_mismatch($sformatf("seq %h: result_kind %b, want %b",
                                  want.released_sequence, got.result_kind, want.result_kind));
      if (got.released_sequence !== want.released_sequence)
        report_mismatch($sformatf("released_sequence %h, want %h",
                                  got.released_sequence, want.released_sequence));
      if (got.released_handle !== want.released_handle)
        report_mismatch($sformatf("seq %h: released_handle %h, want %h",
                                  want.released_sequence, got.released_handle,
                                  want.released_handle));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("seq %h: last_of_run %b, want %b",
                                  want.released_sequence, got.last_of_run, want.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      next_seq  = '0;
      head_slot = 0;
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        held_valid[i]  = 1'b0;
        held_handle[i] = '0;
      end
      release_queue.delete();
    end else begin
      // input first, so a same-cycle result still finds its expectation
      if (in_valid && in_ready) predict_response(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
    pending = release_queue.size();
  end

endmodule

/* bench/tb_in_order_response_reorder_top.sv */
// Testbench top for the in-order response reorder block: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb_in_order_response_reorder_top;
  import ior_pkg::*;

  localparam int RANDOM_ITEMS = 480;
  localparam int CYCLE_LIMIT  = 600000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycle_count;
  int        sent_count;
  int        burst_left;
  logic [SEQ_BITS-1:0] base_seq;

  in_order_response_reorder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  in_order_response_reorder_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Sender: bursts of transfers separated by random gaps, valid held until accepted.
  task automatic send_item(input logic [SEQ_BITS-1:0] seq, input logic [HANDLE_BITS-1:0] handle);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid                <= 1'b1;
    in_data.sequence_number <= seq;
    in_data.payload_handle  <= handle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // Receiver: switches between stall patterns at random intervals.
  initial begin
    int mode;
    int mode_left;
    int phase;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      phase++;
      unique case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (phase % 3 == 0);
      endcase
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int k;
    int tmp;
    int pick;
    int perm [16];
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    sent_count = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, stale, edge of window, duplicate, full drain
    send_item(16'h0000, 32'h0000_0000);   // expected, released alone
    send_item(16'h0000, 32'hFFFF_FFFF);   // stale
    send_item(16'hFFFF, 32'hFFFF_FFFF);   // stale, far end of the number space
    send_item(16'd16, 32'hA5A5_5A5A);     // last slot of the window
    send_item(16'd17, 32'h5A5A_A5A5);     // one past the window
    send_item(16'd16, 32'h1234_5678);     // duplicate of a held slot
    for (int s = 2; s <= 15; s++) send_item(s[SEQ_BITS-1:0], $urandom);
    send_item(16'd1, 32'hFFFF_FFFF);      // releases the whole window
    send_item(16'h8010, 32'h8000_0001);   // far outside the window
    base_seq = 16'd17;

    // random: shuffled runs of consecutive numbers with some noise mixed in
    while (sent_count < RANDOM_ITEMS + 22) begin
      k = ($urandom_range(0, 7) == 0) ? WINDOW_SLOTS : $urandom_range(1, 8);
      for (int i = 0; i < k; i++) perm[i] = i;
      for (int i = k - 1; i > 0; i--) begin
        pick       = $urandom_range(0, i);
        tmp        = perm[i];
        perm[i]    = perm[pick];
        perm[pick] = tmp;
      end
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          if (i > 0 && $urandom_range(0, 1) == 0)
            // resend of one already in: duplicate if held, stale if released
            send_item(SEQ_BITS'(base_seq + perm[$urandom_range(0, i - 1)]), $urandom);
          else
            send_item(SEQ_BITS'(base_seq + 32 + $urandom_range(0, 65472)), $urandom);
        end
        send_item(SEQ_BITS'(base_seq + perm[i]), $urandom);
      end
      base_seq = SEQ_BITS'(base_seq + k);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
